@@ src/gsa_pkg.sv @@
package gsa_pkg;

	// Widths of the handle fields and of the reported live count.
	localparam int IDX_W = 7;
	localparam int GEN_W = 8;
	localparam int CNT_OUT_W = 8;

	// Operation requested by an input beat. The unused code behaves as a check.
	typedef enum logic [1:0] {
		KIND_ALLOC = 2'd0,
		KIND_DROP  = 2'd1,
		KIND_CHECK = 2'd2
	} kind_t;

	// Status reported with each result beat.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_STALE = 2'd2
	} status_t;

	// Cycles from the accepting edge to the edge that takes the result.
	localparam int RESULT_LATENCY = 3;

endpackage

@@ src/gsa_ram.sv @@
module gsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read at the address being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/gsa_free_finder.sv @@
module gsa_free_finder #(
	parameter int SLOT_COUNT = 128,
	parameter int AW = $clog2(SLOT_COUNT)
) (
	input  logic [SLOT_COUNT-1:0] used,
	input  logic                  rel_valid,
	input  logic [AW-1:0]         rel_addr,
	output logic                  found,
	output logic [AW-1:0]         addr
);

	logic          pe_found;
	logic [AW-1:0] pe_addr;

	// Lowest clear bit of the used vector.
	always_comb begin
		pe_found = 1'b0;
		pe_addr  = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used[i]) begin
				pe_found = 1'b1;
				pe_addr  = AW'(i);
			end
		end
	end

	// A slot being released in the same cycle still shows as used in the
	// vector, so it competes here as a second candidate.
	always_comb begin
		found = pe_found | rel_valid;
		if (rel_valid && (!pe_found || (rel_addr < pe_addr))) begin
			addr = rel_addr;
		end else begin
			addr = pe_addr;
		end
	end

endmodule

@@ src/generational_slot_allocator_core.sv @@
// Generational slot allocator.
//
// Input channel: an operation beat (kind, slot_index, slot_generation) is taken at
// a rising edge where start is high and busy is low. busy is held low, so a new
// beat can be taken in every cycle; kind selects allocate, drop or check, and the
// fourth code acts as a check.
//
// Result channel: exactly one result beat per operation, in order. done is high
// for one cycle with handle_index, handle_generation, handle_live, status and
// live_count. The result of a beat passes through s1, s2 and the result register,
// and one operation per cycle is sustained. The receiver cannot stall, so no
// result is ever held or dropped.
//
// The beat is registered (s1), where a priority encoder over the used flags picks
// the lowest free slot and the generation memory is read. In s2 the handle is
// checked and the table, flags and count are updated; the result register follows.
// Updates from s2 are forwarded to s1 and to the memory read.
//
// Reset clears the used flags, the live count and the fill mark of the generation
// memory; unwritten slots, at or above the fill mark, read as generation zero.
module generational_slot_allocator_core
	import gsa_pkg::*;
#(
	parameter int SLOT_COUNT = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           kind,
	input  logic [IDX_W-1:0]     slot_index,
	input  logic [GEN_W-1:0]     slot_generation,
	output logic                 done,
	output logic [IDX_W-1:0]     handle_index,
	output logic [GEN_W-1:0]     handle_generation,
	output logic                 handle_live,
	output logic [1:0]           status,
	output logic [CNT_OUT_W-1:0] live_count
);

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int HW = $clog2(SLOT_COUNT + 1);

	logic accept;

	// Stage 1: registered input beat.
	logic             valid_s1;
	logic [1:0]       kind_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [GEN_W-1:0] gen_s1;

	// Stage 2: beat with its resolved slot address.
	logic             valid_s2;
	logic [1:0]       kind_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [GEN_W-1:0] gen_s2;
	logic [AW-1:0]    addr_s2;
	logic             found_s2;
	logic             in_range_s2;

	// Slot state.
	logic [SLOT_COUNT-1:0] used_q;
	logic [HW-1:0]         count_q;
	logic [HW-1:0]         fill_q;

	// Last memory write, replayed to the following read.
	logic             byp_valid_q;
	logic [AW-1:0]    byp_addr_q;
	logic [GEN_W-1:0] byp_data_q;

	// Result register.
	logic                 done_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic [GEN_W-1:0]     res_gen_q;
	logic                 res_live_q;
	status_t              res_status_q;
	logic [CNT_OUT_W-1:0] res_count_q;

	logic                  in_range_s1;
	logic                  alloc_s1;
	logic [SLOT_COUNT-1:0] used_eff;
	logic                  fnd_found;
	logic [AW-1:0]         fnd_addr;
	logic [AW-1:0]         rd_addr;
	logic [GEN_W-1:0]      ram_rdata;

	logic             alloc_s2;
	logic             drop_s2;
	logic [GEN_W-1:0] gen_rd;
	logic [GEN_W-1:0] gen_cur;
	logic             used_bit;
	logic             match;
	logic             alloc_ok;
	logic             drop_live;
	logic             wr_en;
	logic [GEN_W-1:0] wr_data;
	logic [HW-1:0]    count_nxt;
	status_t          status_nxt;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			idx_s1  <= slot_index;
			gen_s1  <= slot_generation;
		end
	end

	// Stage 1: pick the slot. The allocation committing in s2 this cycle is
	// folded into the used flags; a live drop in s2 is offered as a candidate.
	assign alloc_s1    = (kind_s1 == KIND_ALLOC);
	assign in_range_s1 = (32'(idx_s1) < 32'(SLOT_COUNT));
	assign used_eff    = used_q | (alloc_ok ? (SLOT_COUNT'(1) << addr_s2) : '0);

	gsa_free_finder #(
		.SLOT_COUNT (SLOT_COUNT),
		.AW         (AW)
	) u_finder (
		.used      (used_eff),
		.rel_valid (drop_live),
		.rel_addr  (addr_s2),
		.found     (fnd_found),
		.addr      (fnd_addr)
	);

	assign rd_addr = alloc_s1 ? fnd_addr : AW'(idx_s1);

	gsa_ram #(
		.WIDTH (GEN_W),
		.DEPTH (SLOT_COUNT),
		.AW    (AW)
	) u_gen_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s2),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s2     <= kind_s1;
		idx_s2      <= idx_s1;
		gen_s2      <= gen_s1;
		addr_s2     <= rd_addr;
		found_s2    <= fnd_found;
		in_range_s2 <= in_range_s1;
	end

	// Stage 2: the generation word is the bypassed write if the previous beat
	// wrote this slot, and zero for a slot at or beyond the fill mark.
	assign gen_rd   = (byp_valid_q && (byp_addr_q == addr_s2)) ? byp_data_q : ram_rdata;
	assign gen_cur  = (HW'(addr_s2) < fill_q) ? gen_rd : '0;
	assign used_bit = in_range_s2 ? used_q[addr_s2] : 1'b0;
	assign match    = used_bit && (gen_cur == gen_s2);

	assign alloc_s2  = (kind_s2 == KIND_ALLOC);
	assign drop_s2   = (kind_s2 == KIND_DROP);
	assign alloc_ok  = valid_s2 & alloc_s2 & found_s2;
	assign drop_live = valid_s2 & drop_s2 & match;
	assign wr_en     = alloc_ok | drop_live;

	always_comb begin
		if (alloc_ok) begin
			wr_data = (gen_cur == '0) ? GEN_W'(1) : gen_cur;
		end else begin
			wr_data = gen_cur + GEN_W'(1);
		end
	end

	always_comb begin
		if (alloc_ok) begin
			count_nxt = count_q + HW'(1);
		end else if (drop_live) begin
			count_nxt = count_q - HW'(1);
		end else begin
			count_nxt = count_q;
		end
	end

	always_comb begin
		if (alloc_s2) begin
			status_nxt = found_s2 ? ST_OK : ST_FULL;
		end else if (drop_s2 && !match) begin
			status_nxt = ST_STALE;
		end else begin
			status_nxt = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			byp_valid_q <= 1'b0;
		end else begin
			if (alloc_ok) begin
				used_q[addr_s2] <= 1'b1;
			end else if (drop_live) begin
				used_q[addr_s2] <= 1'b0;
			end
			count_q <= count_nxt;
			// Allocation is always lowest first, so the written slots form a prefix.
			if (alloc_ok && (HW'(addr_s2) == fill_q)) begin
				fill_q <= fill_q + HW'(1);
			end
			byp_valid_q <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		byp_addr_q <= addr_s2;
		byp_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_idx_q    <= alloc_ok ? IDX_W'(addr_s2) : idx_s2;
			res_gen_q    <= alloc_ok ? wr_data : gen_s2;
			res_live_q   <= alloc_s2 ? found_s2 : match;
			res_status_q <= status_nxt;
			res_count_q  <= CNT_OUT_W'(count_nxt);
		end
	end

	assign done              = done_q;
	assign handle_index      = res_idx_q;
	assign handle_generation = res_gen_q;
	assign handle_live       = res_live_q;
	assign status            = res_status_q;
	assign live_count        = res_count_q;

endmodule

@@ src/gsa_checker.sv @@
module gsa_checker
	import gsa_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [GEN_W-1:0] handle_generation,
	input logic             handle_live,
	input logic [1:0]       status
);

	// Every accepted beat yields a result beat a fixed time later.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##RESULT_LATENCY done)
		else $error("accepted beat produced no result");

	// No result beat appears without an accepted beat behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##RESULT_LATENCY !done)
		else $error("result beat without an accepted beat");

	// A live handle never carries generation zero.
	a_live_gen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && handle_live) |-> (handle_generation != '0))
		else $error("live handle with generation zero");

	// A full table or a stale drop never reports a live handle.
	a_fail_not_live: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ((status == ST_FULL) || (status == ST_STALE))) |-> !handle_live)
		else $error("failed operation reports a live handle");

endmodule

bind generational_slot_allocator_core gsa_checker u_gsa_checker (.*);

@@ sim/generational_slot_allocator_core_tb.sv @@
module generational_slot_allocator_core_tb;
	import gsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_COUNT = 128;
	// The package names three operations; the fourth code has to act as a check.
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int RANDOM_BEATS = 150;
	// Enough drop/allocate pairs on slot zero to carry its generation past 255.
	localparam int WRAP_BEATS = 520;

	// One result beat as the block reports it.
	typedef struct {
		logic [IDX_W-1:0]     idx;
		logic [GEN_W-1:0]     gen;
		logic                 live;
		status_t              status;
		logic [CNT_OUT_W-1:0] count;
	} result_t;

	// One row of the directed table. Rows with pinned set carry a result that can
	// be read straight off the spec; the others are left to the predictor.
	typedef struct {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
		logic [GEN_W-1:0] gen;
		bit               pinned;
		result_t          want;
	} directed_row_t;

	// Traffic mixes of the random part. Each segment of the run picks one.
	typedef enum int {
		MIX_FILL,
		MIX_EMPTY,
		MIX_CHURN,
		MIX_TO_FULL
	} traffic_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           kind;
	logic [IDX_W-1:0]     slot_index;
	logic [GEN_W-1:0]     slot_generation;
	logic                 done;
	logic [IDX_W-1:0]     handle_index;
	logic [GEN_W-1:0]     handle_generation;
	logic                 handle_live;
	logic [1:0]           status;
	logic [CNT_OUT_W-1:0] live_count;

	generational_slot_allocator_core #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.kind              (kind),
		.slot_index        (slot_index),
		.slot_generation   (slot_generation),
		.done              (done),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.handle_live       (handle_live),
		.status            (status),
		.live_count        (live_count)
	);

	// Shadow copy of the slot table. It is updated at the edge that takes each
	// operation beat, so when the driver picks its next beat it already sees
	// the effect of every beat sent so far.
	bit               slot_in_use [SLOT_COUNT];
	logic [GEN_W-1:0] slot_gen_tbl [SLOT_COUNT];
	int               used_total;

	// Results owed by the block, oldest first.
	result_t owed_results [$];
	int      ops_taken;
	int      mismatches;

	// Hand-off from the driver to the monitor for rows with a typed-in result.
	bit      use_pinned;
	result_t pinned;

	// When set, the sender runs back to back with no gaps.
	bit no_idle;

	directed_row_t directed_rows [$];
	result_t       blank;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs; the slowest legal run is far shorter.
	initial begin
		#2_000_000;
		$display("generational_slot_allocator_core_tb failed");
		$finish;
	end

	// Applies one operation to the shadow table and returns the result the block
	// must report for it. A handle is live only when its slot is in use and the
	// generations agree; a slot at generation zero is bumped to one as it is
	// handed out, so generation zero never names a live slot.
	function automatic result_t apply_to_table(input logic [1:0] k,
			input logic [IDX_W-1:0] i, input logic [GEN_W-1:0] g);
		result_t r;
		bit      hit;
		bit      found;
		int      f;
		r.idx    = i;
		r.gen    = g;
		r.live   = 1'b0;
		r.status = ST_OK;
		hit   = (int'(i) < SLOT_COUNT) && slot_in_use[i] && (slot_gen_tbl[i] == g);
		found = 1'b0;
		f     = 0;
		case (k)
			KIND_ALLOC: begin
				for (int s = 0; s < SLOT_COUNT; s++) begin
					if (!found && !slot_in_use[s]) begin
						found = 1'b1;
						f     = s;
					end
				end
				if (found) begin
					if (slot_gen_tbl[f] == '0)
						slot_gen_tbl[f] = GEN_W'(1);
					slot_in_use[f] = 1'b1;
					used_total++;
					r.idx  = f[IDX_W-1:0];
					r.gen  = slot_gen_tbl[f];
					r.live = 1'b1;
				end else begin
					r.status = ST_FULL;
				end
			end
			KIND_DROP: begin
				if (hit) begin
					slot_gen_tbl[i] = slot_gen_tbl[i] + 1'b1;
					slot_in_use[i]  = 1'b0;
					if (used_total > 0)
						used_total--;
					r.live = 1'b1;
				end else begin
					r.status = ST_STALE;
				end
			end
			default: r.live = hit;
		endcase
		r.count = used_total[CNT_OUT_W-1:0];
		return r;
	endfunction

	// Monitor. Everything is sampled at the rising edge; inputs only move at the
	// falling edge, and the block's outputs are read before its own updates land.
	// A result beat is checked before the new operation beat is predicted, which
	// keeps the owed queue in the order the block must answer.
	always @(posedge clk) begin
		result_t want;
		if (done === 1'b1) begin
			if (owed_results.size() == 0) begin
				$error("result beat with no operation outstanding");
				mismatches++;
			end else begin
				want = owed_results.pop_front();
				if (handle_index !== want.idx) begin
					$error("handle_index: expected %0d, got %0d", want.idx, handle_index);
					mismatches++;
				end
				if (handle_generation !== want.gen) begin
					$error("handle_generation: expected %0d, got %0d",
						want.gen, handle_generation);
					mismatches++;
				end
				if (handle_live !== want.live) begin
					$error("handle_live: expected %0d, got %0d", want.live, handle_live);
					mismatches++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (live_count !== want.count) begin
					$error("live_count: expected %0d, got %0d", want.count, live_count);
					mismatches++;
				end
			end
		end
		if (start && busy === 1'b0) begin
			// The table must move even when the row carries its own answer.
			want = apply_to_table(kind, slot_index, slot_generation);
			if (use_pinned)
				want = pinned;
			owed_results.push_back(want);
			ops_taken++;
		end
	end

	// Drives one operation beat and returns at the falling edge after the block
	// took it. start stays high on return, so a back-to-back beat follows with
	// no bubble; a gap lowers it first.
	task automatic send_beat(input logic [1:0] k, input logic [IDX_W-1:0] i,
			input logic [GEN_W-1:0] g, input bit typed, input result_t want);
		int gap;
		int seen;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start           <= 1'b1;
		kind            <= k;
		slot_index      <= i;
		slot_generation <= g;
		use_pinned = typed;
		pinned     = want;
		seen       = ops_taken;
		do @(negedge clk); while (ops_taken == seen);
	endtask

	// Holds the sender off until every owed result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (owed_results.size() != 0);
	endtask

	task automatic add_row(input logic [1:0] k, input int i, input int g, input int typed,
			input int wi, input int wg, input int wl, input status_t ws, input int wc);
		directed_row_t row;
		row.kind        = k;
		row.idx         = i[IDX_W-1:0];
		row.gen         = g[GEN_W-1:0];
		row.pinned      = typed[0];
		row.want.idx    = wi[IDX_W-1:0];
		row.want.gen    = wg[GEN_W-1:0];
		row.want.live   = wl[0];
		row.want.status = ws;
		row.want.count  = wc[CNT_OUT_W-1:0];
		directed_rows.push_back(row);
	endtask

	// Lowest-effort random choice of a slot that is in use, or -1 if none is.
	function automatic int pick_live_slot();
		int live_slots [$];
		for (int s = 0; s < SLOT_COUNT; s++)
			if (slot_in_use[s])
				live_slots.push_back(s);
		if (live_slots.size() == 0)
			return -1;
		return live_slots[$urandom_range(0, live_slots.size() - 1)];
	endfunction

	// Builds a handle that is not live: either a used slot with a wrong
	// generation, or a free slot, often with the generation it last had.
	task automatic pick_stale_handle(output logic [IDX_W-1:0] i, output logic [GEN_W-1:0] g);
		i = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
		if (slot_in_use[i])
			g = slot_gen_tbl[i] + GEN_W'($urandom_range(1, 255));
		else if ($urandom_range(0, 1) == 0)
			g = slot_gen_tbl[i];
		else
			g = GEN_W'($urandom_range(0, 255));
	endtask

	// Chooses the next random beat for the given traffic mix. Most drops and
	// checks use handles that are live right now, so they reach the paths that
	// change the table instead of bouncing off as stale.
	task automatic pick_beat(input traffic_t mix, output logic [1:0] k,
			output logic [IDX_W-1:0] i, output logic [GEN_W-1:0] g);
		int roll;
		int s;
		roll = $urandom_range(0, 99);
		s    = pick_live_slot();
		i    = IDX_W'($urandom_range(0, SLOT_COUNT - 1));
		g    = GEN_W'($urandom_range(0, 255));
		k    = KIND_ALLOC;
		case (mix)
			MIX_FILL:
				if (roll >= 80)
					k = (roll < 90) ? KIND_CHECK : KIND_DROP;
			MIX_EMPTY:
				if (roll < 70)
					k = KIND_DROP;
				else if (roll < 85)
					k = KIND_CHECK;
			MIX_CHURN:
				if (roll < 30)
					k = KIND_ALLOC;
				else if (roll < 55)
					k = KIND_DROP;
				else if (roll < 70)
					k = KIND_CHECK;
				else if (roll < 90) begin
					k = (roll < 80) ? KIND_DROP : KIND_CHECK;
					pick_stale_handle(i, g);
					s = -1;
				end else if (roll < 95) begin
					// The spare code, aimed at a live handle half of the time.
					k = KIND_SPARE;
					if ($urandom_range(0, 1) == 0)
						s = -1;
				end else begin
					// Pure noise across every field.
					k = 2'($urandom_range(0, 3));
					s = -1;
				end
			default: k = KIND_ALLOC;
		endcase
		if (k != KIND_ALLOC && s >= 0) begin
			i = s[IDX_W-1:0];
			g = slot_gen_tbl[s];
		end
	endtask

	initial begin
		logic [1:0]       k;
		logic [IDX_W-1:0] i;
		logic [GEN_W-1:0] g;
		traffic_t         mix;
		int               seg_len;
		int               sent;
		bit               drained_once;

		arst_n          = 1'b0;
		start           = 1'b0;
		kind            = KIND_CHECK;
		slot_index      = '0;
		slot_generation = '0;
		use_pinned      = 1'b0;
		no_idle         = 1'b0;
		ops_taken       = 0;
		mismatches      = 0;
		used_total      = 0;
		drained_once    = 1'b0;
		blank           = '{idx: '0, gen: '0, live: 1'b0, status: ST_OK, count: '0};
		for (int s = 0; s < SLOT_COUNT; s++) begin
			slot_in_use[s]  = 1'b0;
			slot_gen_tbl[s] = '0;
		end

		// Directed table. The first rows run on a freshly reset table, where the
		// answers are plain: nothing is live, generation zero is never live, and
		// the first two allocations hand out slots zero and one at generation one.
		add_row(KIND_CHECK, 0, 0, 1, 0, 0, 0, ST_OK, 0);
		add_row(KIND_DROP, 127, 255, 1, 127, 255, 0, ST_STALE, 0);
		add_row(KIND_SPARE, 127, 255, 1, 127, 255, 0, ST_OK, 0);
		add_row(KIND_ALLOC, 'h55, 'hAA, 1, 0, 1, 1, ST_OK, 1);
		add_row(KIND_ALLOC, 127, 255, 1, 1, 1, 1, ST_OK, 2);
		add_row(KIND_CHECK, 0, 1, 1, 0, 1, 1, ST_OK, 2);
		add_row(KIND_CHECK, 0, 0, 1, 0, 0, 0, ST_OK, 2);
		add_row(KIND_SPARE, 1, 1, 1, 1, 1, 1, ST_OK, 2);
		add_row(KIND_DROP, 0, 2, 1, 0, 2, 0, ST_STALE, 2);
		add_row(KIND_DROP, 0, 1, 1, 0, 1, 1, ST_OK, 1);
		add_row(KIND_CHECK, 0, 1, 1, 0, 1, 0, ST_OK, 1);
		add_row(KIND_DROP, 0, 1, 1, 0, 1, 0, ST_STALE, 1);
		// From here the predictor supplies the answers: reuse of a slot whose
		// generation is already past zero, and a hole below the top of the table.
		add_row(KIND_ALLOC, 0, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_DROP, 1, 1, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_ALLOC, 127, 0, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_CHECK, 1, 2, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_CHECK, 127, 255, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_DROP, 0, 2, 0, 0, 0, 0, ST_OK, 0);
		add_row(KIND_DROP, 1, 2, 0, 0, 0, 0, ST_OK, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[r])
			send_beat(directed_rows[r].kind, directed_rows[r].idx, directed_rows[r].gen,
				directed_rows[r].pinned, directed_rows[r].want);

		// Let the pipeline empty before the long stretch of slot-zero recycling.
		wait_drained();
		drained_once = 1'b1;

		// Recycle slot zero until its generation wraps through zero and is bumped
		// back to one on the next allocation. Slot zero is always the lowest free
		// slot once dropped, so each drop/allocate pair bumps it once.
		no_idle = 1'b1;
		for (int n = 0; n < WRAP_BEATS; n++) begin
			if ($urandom_range(0, 7) == 0)
				no_idle = !no_idle;
			if (slot_in_use[0])
				send_beat(KIND_DROP, '0, slot_gen_tbl[0], 1'b0, blank);
			else
				send_beat(KIND_ALLOC, IDX_W'($urandom), GEN_W'($urandom), 1'b0, blank);
		end

		// Random part, in segments of one traffic mix each. Filling to the top
		// is forced early so table-full allocations show up in every run.
		sent = 0;
		mix  = MIX_TO_FULL;
		while (sent < RANDOM_BEATS) begin
			no_idle = ($urandom_range(0, 2) == 0);
			if (mix == MIX_TO_FULL)
				seg_len = SLOT_COUNT - used_total + $urandom_range(2, 5);
			else
				seg_len = $urandom_range(10, 40);
			for (int n = 0; n < seg_len; n++) begin
				if (mix == MIX_TO_FULL) begin
					k = KIND_ALLOC;
					i = IDX_W'($urandom);
					g = GEN_W'($urandom);
				end else begin
					pick_beat(mix, k, i, g);
				end
				send_beat(k, i, g, 1'b0, blank);
				sent++;
			end
			if ($urandom_range(0, 3) == 0)
				wait_drained();
			case ($urandom_range(0, 9))
				0, 1, 2:    mix = MIX_CHURN;
				3, 4:       mix = MIX_FILL;
				5, 6, 7:    mix = MIX_EMPTY;
				default:    mix = MIX_TO_FULL;
			endcase
		end

		wait_drained();
		repeat (RESULT_LATENCY + 4) @(negedge clk);
		if (drained_once && mismatches == 0)
			$display("generational_slot_allocator_core_tb passed");
		else
			$display("generational_slot_allocator_core_tb failed");
		$finish;
	end

endmodule
